/* src/double_ended_queue_core_assert.svh */
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Same-cycle and next-cycle implication checks, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// ante true implies cons true in the same cycle
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante true implies cons true in the next cycle
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Depth, widths, request codes and cell control types for the deque core.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int REQ_W   = 3;
  localparam int ENTRY_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [REQ_W-1:0]         req_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;

  localparam data_t DATA_NONE = '1;  // -1

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,  // take left neighbor, head takes wr_data
    CELL_SHIFT_OUT = 2'd2,  // take right neighbor
    CELL_WRITE_AT  = 2'd3   // selected cell takes wr_data
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    data_t     wr_data;
  } cell_ctrl_t;

endpackage

/* src/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit values with one result per request.
// ----------------------------------------------------------------------------
// The core takes one request per clock unless in_stall holds it off, and
// returns its result in the next cycle from an output register; a new request
// is taken in the same cycle as the previous result is transferred, so a steady
// stream runs at one request per cycle. The queue lives in two rows of DEPTH
// cells that hold the same entries in opposite order: the front row has the
// front entry in cell 0, the back row has the back entry in cell 0. A push or
// pop at one end shifts that end's row by one cell, while
// the other row appends at, or drops, the cell indexed by the entry count.
// Both ends are therefore always at a fixed cell and no read mux is needed;
// the cell update sets the rate. Storage is 2*DEPTH words. A
// push to a full queue is dropped and flagged, a pop from an empty queue
// returns -1 and is flagged; request codes 4 to 7 act as a query.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [deq_pkg::REQ_W-1:0]   in_req_type,
  input  logic signed [deq_pkg::DATA_W-1:0] in_push_value,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [deq_pkg::DATA_W-1:0] out_popped_value,
  output logic                        out_pop_missed,
  output logic                        out_push_dropped,
  output logic [deq_pkg::ENTRY_W-1:0] out_entry_count,
  output logic                        out_is_empty,
  output logic signed [deq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0] out_back_value
);

  // control state
  deq_pkg::cnt_t  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  // result payload
  deq_pkg::data_t popped_r, popped_nxt;
  logic           missed_r, missed_nxt;
  logic           dropped_r, dropped_nxt;

  deq_pkg::cell_ctrl_t front_ctrl, back_ctrl;
  deq_pkg::data_t      front_head, back_head;

  logic in_xfer;
  logic is_full, is_void;

  // Hold off new requests only while a result waits and is stalled.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  assign is_full = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_void = (count_r == '0);

  always_comb begin
    front_ctrl.cmd     = deq_pkg::CELL_HOLD;
    front_ctrl.wr_data = in_push_value;
    back_ctrl.cmd      = deq_pkg::CELL_HOLD;
    back_ctrl.wr_data  = in_push_value;
    count_nxt          = count_r;
    popped_nxt         = popped_r;
    missed_nxt         = missed_r;
    dropped_nxt        = dropped_r;
    out_valid_nxt      = out_valid_r & out_stall;

    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = deq_pkg::DATA_NONE;
      missed_nxt    = 1'b0;
      dropped_nxt   = 1'b0;
      case (in_req_type)
        deq_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            dropped_nxt = 1'b1;
          end else begin
            // new front: front row shifts in, back row appends at count
            front_ctrl.cmd = deq_pkg::CELL_SHIFT_IN;
            back_ctrl.cmd  = deq_pkg::CELL_WRITE_AT;
            count_nxt      = count_r + deq_pkg::cnt_t'(1);
          end
        end
        deq_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            dropped_nxt = 1'b1;
          end else begin
            back_ctrl.cmd  = deq_pkg::CELL_SHIFT_IN;
            front_ctrl.cmd = deq_pkg::CELL_WRITE_AT;
            count_nxt      = count_r + deq_pkg::cnt_t'(1);
          end
        end
        deq_pkg::REQ_POP_FRONT: begin
          if (is_void) begin
            missed_nxt = 1'b1;
          end else begin
            // the back row just loses its last cell via the count
            popped_nxt     = front_head;
            front_ctrl.cmd = deq_pkg::CELL_SHIFT_OUT;
            count_nxt      = count_r - deq_pkg::cnt_t'(1);
          end
        end
        deq_pkg::REQ_POP_BACK: begin
          if (is_void) begin
            missed_nxt = 1'b1;
          end else begin
            popped_nxt    = back_head;
            back_ctrl.cmd = deq_pkg::CELL_SHIFT_OUT;
            count_nxt     = count_r - deq_pkg::cnt_t'(1);
          end
        end
        default: begin
          // query only
        end
      endcase
    end
  end

  deq_chain u_front_row (
    .clk   (clk),
    .ctrl  (front_ctrl),
    .count (count_r),
    .head  (front_head)
  );

  deq_chain u_back_row (
    .clk   (clk),
    .ctrl  (back_ctrl),
    .count (count_r),
    .head  (back_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r  <= popped_nxt;
    missed_r  <= missed_nxt;
    dropped_r <= dropped_nxt;
  end

  // Queue status comes straight from the state, which holds while the
  // result is stalled since no new request is taken then.
  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_pop_missed   = missed_r;
  assign out_push_dropped = dropped_r;
  assign out_entry_count  = deq_pkg::ENTRY_W'(count_r);
  assign out_is_empty     = is_void;
  assign out_front_value  = is_void ? deq_pkg::DATA_NONE : front_head;
  assign out_back_value   = is_void ? deq_pkg::DATA_NONE : back_head;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DEQ_ASSERT_SAME(a_count_range, 1'b1, count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH),
    "entry count beyond depth")
  `DEQ_ASSERT_NEXT(a_full_drop,
    in_xfer && is_full && (in_req_type == deq_pkg::REQ_PUSH_FRONT ||
      in_req_type == deq_pkg::REQ_PUSH_BACK),
    out_push_dropped && $stable(count_r), "push to full queue not dropped")
  `DEQ_ASSERT_NEXT(a_empty_miss,
    in_xfer && is_void && (in_req_type == deq_pkg::REQ_POP_FRONT ||
      in_req_type == deq_pkg::REQ_POP_BACK),
    out_pop_missed && out_popped_value == deq_pkg::DATA_NONE && out_is_empty,
    "pop from empty queue not flagged")
  `DEQ_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
    $stable(count_r) && out_valid, "state moved under a stalled result")

endmodule

/* src/deq_cell.sv */
// ----------------------------------------------------------------------------
// Deque cell
// One storage word of a chain; moves toward either neighbor or loads data.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic               clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  logic               sel,
  input  deq_pkg::data_t     left_data,
  input  deq_pkg::data_t     right_data,
  output deq_pkg::data_t     data
);

  deq_pkg::data_t data_r;
  deq_pkg::data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      deq_pkg::CELL_SHIFT_IN:  data_nxt = left_data;
      deq_pkg::CELL_SHIFT_OUT: data_nxt = right_data;
      deq_pkg::CELL_WRITE_AT:  data_nxt = sel ? ctrl.wr_data : data_r;
      default:                 data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* src/deq_chain.sv */
// ----------------------------------------------------------------------------
// Deque chain
// Row of DEPTH cells, head at cell 0, occupied cells 0 .. count-1.
// ----------------------------------------------------------------------------
module deq_chain (
  input  logic                clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  deq_pkg::cnt_t       count,
  output deq_pkg::data_t      head
);

  deq_pkg::data_t cell_q [deq_pkg::DEPTH];

  for (genvar k = 0; k < deq_pkg::DEPTH; k++) begin : g_cell
    deq_pkg::data_t left_d;
    deq_pkg::data_t right_d;
    logic           sel;

    if (k == 0) begin : g_head
      assign left_d = ctrl.wr_data;
    end else begin : g_mid
      assign left_d = cell_q[k-1];
    end

    if (k == deq_pkg::DEPTH - 1) begin : g_tail
      assign right_d = cell_q[k];  // beyond the occupied range, never read
    end else begin : g_body
      assign right_d = cell_q[k+1];
    end

    // the cell just past the last entry takes an append
    assign sel = (count == deq_pkg::CNT_W'(k));

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sel        (sel),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[k])
    );
  end

  assign head = cell_q[0];

endmodule
